[design/assert_macros.svh]
// Assertion macros shared by the estimator RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHECK_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication.
`define CHECK_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

[design/phse_pkg.sv]
// Package for the pose heading and speed estimator: types and constants.
// No dependencies.
`timescale 1ns / 1ps
package phse_pkg;
   localparam logic [1:0] ACT_POSE = 2'd0;
   localparam logic [1:0] ACT_FAIL = 2'd1;
   localparam logic [1:0] ACT_FEEDBACK = 2'd2;
   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam logic [0:0] REG_ALPHA = 1'd0;
   localparam logic [0:0] REG_FLATTEN = 1'd1;
   localparam logic signed [31:0] ANG_HALF_PI = 32'sd843314857;
   localparam logic signed [15:0] HEAD_MAX = 16'sd25736;
   localparam logic [29:0] NS_PER_S = 30'd1000000000;

   typedef struct packed {
      logic [1:0] action;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic [62:0] stamp_ns;
      logic signed [31:0] feedback_speed_in;
   } req_type;

   typedef struct packed {
      logic valid_res;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [15:0] heading;
      logic signed [31:0] speed;
   } rsp_type;

   function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
      logic signed [31:0] v;
      case (i)
         5'd0: v = 32'sd421657428;
         5'd1: v = 32'sd248918915;
         5'd2: v = 32'sd131521918;
         5'd3: v = 32'sd66762579;
         5'd4: v = 32'sd33510843;
         5'd5: v = 32'sd16771758;
         5'd6: v = 32'sd8387925;
         5'd7: v = 32'sd4194219;
         5'd8: v = 32'sd2097141;
         5'd9: v = 32'sd1048575;
         5'd10: v = 32'sd524288;
         5'd11: v = 32'sd262144;
         5'd12: v = 32'sd131072;
         5'd13: v = 32'sd65536;
         5'd14: v = 32'sd32768;
         5'd15: v = 32'sd16384;
         5'd16: v = 32'sd8192;
         5'd17: v = 32'sd4096;
         5'd18: v = 32'sd2048;
         5'd19: v = 32'sd1024;
         5'd20: v = 32'sd512;
         5'd21: v = 32'sd256;
         5'd22: v = 32'sd128;
         5'd23: v = 32'sd64;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction
endpackage

[design/phse_if.sv]
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; the payload type is a parameter.
`timescale 1ns / 1ps
interface phse_if #(parameter type payload_type = logic) ();
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[design/phse_cordic.sv]
// Iterative CORDIC vectoring unit: yaw angle of a 2D vector in Q3.13.
// Depends on phse_pkg (angle table, limits) and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module phse_cordic #(
   parameter int ITERS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [34:0] vx_init,
   input  logic signed [34:0] vy_init,
   output logic done,
   output logic signed [15:0] angle
);
   localparam int NIT = (ITERS < 24) ? ITERS : 24;
   localparam logic [4:0] LAST = 5'(NIT - 1);

   logic busy_ff, busy_in;
   logic [4:0] step_ff, step_in;
   logic signed [37:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [33:0] ang_ff, ang_in;
   logic done_ff, done_in;
   logic signed [15:0] angle_ff, angle_in;
   logic signed [37:0] sx, sy, ex, ey;
   logic signed [33:0] rnd;
   logic signed [17:0] h;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      ang_in = ang_ff;
      done_in = 1'b0;
      angle_in = angle_ff;
      ex = 38'(vx_init);
      ey = 38'(vy_init);
      sx = vx_ff >>> step_ff;
      sy = vy_ff >>> step_ff;
      rnd = ang_ff + 34'sd32768;
      h = 18'(rnd >>> 16);
      if (start) begin
         step_in = 5'd0;
         ang_in = 34'sd0;
         if (vx_init == 35'sd0 && vy_init == 35'sd0) begin
            done_in = 1'b1;
            angle_in = 16'sd0;
            busy_in = 1'b0;
         end else begin
            busy_in = 1'b1;
            if (vx_init < 0) begin
               if (vy_init >= 0) begin
                  vx_in = ey; vy_in = -ex; ang_in = 34'(phse_pkg::ANG_HALF_PI);
               end else begin
                  vx_in = -ey; vy_in = ex; ang_in = -34'(phse_pkg::ANG_HALF_PI);
               end
            end else begin
               vx_in = ex; vy_in = ey;
            end
         end
      end else if (busy_ff) begin
         if (vy_ff > 0) begin
            vx_in = vx_ff + sy; vy_in = vy_ff - sx;
            ang_in = ang_ff + 34'(phse_pkg::atan_entry(step_ff));
         end else begin
            vx_in = vx_ff - sy; vy_in = vy_ff + sx;
            ang_in = ang_ff - 34'(phse_pkg::atan_entry(step_ff));
         end
         step_in = step_ff + 5'd1;
         if (step_ff == LAST) begin
            busy_in = 1'b0;
         end
      end else if (step_ff == LAST + 5'd1) begin
         done_in = 1'b1;
         step_in = 5'd0;
         if (h > 18'(phse_pkg::HEAD_MAX)) angle_in = phse_pkg::HEAD_MAX;
         else if (h < -18'(phse_pkg::HEAD_MAX)) angle_in = -phse_pkg::HEAD_MAX;
         else angle_in = 16'(h);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 5'd0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
      vx_ff <= vx_in;
      vy_ff <= vy_in;
      ang_ff <= ang_in;
      angle_ff <= angle_in;
   end

   assign done = done_ff;
   assign angle = angle_ff;

   `CHECK_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff)
   `CHECK_IMPL(a_range, clock, reset, done_ff,
      angle_ff <= phse_pkg::HEAD_MAX && angle_ff >= -phse_pkg::HEAD_MAX)
endmodule

[design/pose_heading_speed_estimator.sv]
// Steps: a pose item runs through 3 squares, a 35-step square root, 1 scale step, a 31-step
// divide, 2 speed update steps and the output step, which also waits for the CORDIC; a lookup
// failure goes straight to the output step; feedback items give no result.
// Items: one at a time; the next item is taken only once the block is back in idle; a held
// result only delays the output step of the next one.
// Reset: synchronous, active high; state clears, the alpha gain returns to 13107.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pose_heading_speed_estimator #(
   parameter int CORDIC_ITERATIONS = 16,
   parameter int MIN_STEP_NS = 1000
) (
   input  logic clock,
   input  logic reset,
   phse_if.sink req,
   phse_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [2:2] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_SQRT = 4'd2, S_SCALE = 4'd3,
      S_DIV = 4'd4, S_EMA = 4'd5, S_WAITC = 4'd6, S_OUT = 4'd7;

   logic [3:0] st_ff, st_in;
   logic [16:0] alpha_ff;
   logic flat_ff;
   logic have_prev_ff, have_prev_in;
   logic signed [31:0] px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic [62:0] pst_ff, pst_in;
   logic signed [31:0] sm_ff, sm_in;
   logic fb_ff, fb_in;
   logic signed [31:0] fbs_ff, fbs_in;
   phse_pkg::req_type it_ff, it_in;
   logic upd_ff, upd_in;
   logic [62:0] dt_ff, dt_in;
   logic [1:0] k_ff, k_in;
   logic [5:0] b_ff, b_in;
   logic [69:0] acc_ff, acc_in;
   logic [63:0] r_ff, r_in;
   logic [69:0] rsq_ff, rsq_in;
   logic [92:0] dsh_ff, dsh_in;
   logic [63:0] q_ff, q_in;
   logic ang_ok_ff, ang_ok_in;
   logic signed [15:0] head_ff, head_in;
   phse_pkg::rsp_type out_ff, out_in;
   logic ov_ff, ov_in;

   // shared multiplier
   logic [32:0] ma;
   logic [32:0] mb;
   logic [65:0] mp;
   logic [31:0] ad;
   logic [69:0] sq_cand;
   logic signed [49:0] emap;
   logic signed [33:0] snew;
   logic [16:0] a_eff;
   logic signed [32:0] diff;
   logic signed [34:0] cvx, cvy;
   logic cstart, cdone;
   logic signed [15:0] cang;
   logic csr_wr;

   assign mp = 66'(ma) * 66'(mb);

   always_comb begin
      case (k_ff)
         2'd0: ad = (it_ff.pos_x >= px_ff) ? 32'(33'(it_ff.pos_x) - 33'(px_ff))
                                        : 32'(33'(px_ff) - 33'(it_ff.pos_x));
         2'd1: ad = (it_ff.pos_y >= py_ff) ? 32'(33'(it_ff.pos_y) - 33'(py_ff))
                                        : 32'(33'(py_ff) - 33'(it_ff.pos_y));
         default: ad = (it_ff.pos_z >= pz_ff) ? 32'(33'(it_ff.pos_z) - 33'(pz_ff))
                                        : 32'(33'(pz_ff) - 33'(it_ff.pos_z));
      endcase
   end

   // (r + 2^b)^2 = r^2 + r * 2^(b+1) + 2^(2b)
   assign sq_cand = rsq_ff + (70'(r_ff) << (b_ff + 6'd1)) + (70'd1 << {b_ff, 1'b0});

   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? {31'd0, flat_ff} : {15'd0, alpha_ff};
   assign a_eff = (alpha_ff > 17'd65536) ? 17'd65536 : alpha_ff;
   assign diff = 33'(signed'(r_ff[31:0])) - 33'(sm_ff);
   assign emap = 50'(signed'({1'b0, a_eff})) * 50'(diff) + 50'sd32768;
   assign snew = 34'(sm_ff) + 34'(emap >>> 16);

   assign cvy = 35'(2) * (35'(it_in.quat_w) * 35'(it_in.quat_z)
               + 35'(it_in.quat_x) * 35'(it_in.quat_y));
   assign cvx = 35'sd1073741824 - 35'(2) * (35'(it_in.quat_y) * 35'(it_in.quat_y)
               + 35'(it_in.quat_z) * 35'(it_in.quat_z));

   phse_cordic #(.ITERS(CORDIC_ITERATIONS)) u_cordic (
      .clock(clock), .reset(reset), .start(cstart),
      .vx_init(cvx), .vy_init(cvy), .done(cdone), .angle(cang)
   );

   assign req.ready = (st_ff == S_IDLE);
   assign rsp.valid = ov_ff;
   assign rsp.data = out_ff;

   always_comb begin
      st_in = st_ff; have_prev_in = have_prev_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff; pst_in = pst_ff;
      sm_in = sm_ff; fb_in = fb_ff; fbs_in = fbs_ff; it_in = it_ff;
      upd_in = upd_ff; dt_in = dt_ff; k_in = k_ff; b_in = b_ff;
      acc_in = acc_ff; r_in = r_ff; rsq_in = rsq_ff; dsh_in = dsh_ff; q_in = q_ff;
      ang_ok_in = ang_ok_ff; head_in = head_ff; out_in = out_ff; ov_in = ov_ff;
      cstart = 1'b0;
      ma = 33'd0; mb = 33'd0;
      if (ov_ff && rsp.ready) ov_in = 1'b0;
      if (cdone) begin
         ang_ok_in = 1'b1;
         head_in = cang;
      end
      unique case (st_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               it_in = req.data;
               unique case (req.data.action)
                  phse_pkg::ACT_FEEDBACK: begin
                     fb_in = 1'b1; fbs_in = req.data.feedback_speed_in;
                  end
                  phse_pkg::ACT_FAIL: begin
                     have_prev_in = 1'b0;
                     st_in = S_OUT;
                  end
                  phse_pkg::ACT_POSE: begin
                     cstart = 1'b1; ang_ok_in = 1'b0;
                     dt_in = req.data.stamp_ns - pst_ff;
                     upd_in = have_prev_ff && (req.data.stamp_ns > pst_ff)
                        && ((req.data.stamp_ns - pst_ff) > 63'(MIN_STEP_NS));
                     k_in = 2'd0; acc_in = 70'd0;
                     st_in = S_SQ;
                  end
                  default: ;
               endcase
            end
         end
         S_SQ: begin
            ma = 33'(ad); mb = 33'(ad);
            acc_in = acc_ff + 70'(mp);
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd2) begin
               st_in = S_SQRT; b_in = 6'd34; r_in = 64'd0; rsq_in = 70'd0;
            end
         end
         S_SQRT: begin
            if (sq_cand <= acc_ff) begin
               r_in = r_ff | (64'd1 << b_ff);
               rsq_in = sq_cand;
            end
            b_in = b_ff - 6'd1;
            if (b_ff == 6'd0) st_in = S_SCALE;
         end
         S_SCALE: begin
            ma = r_ff[32:0]; mb = 33'(phse_pkg::NS_PER_S);
            acc_in = 70'(mp);
            dsh_in = {dt_ff, 30'd0};
            b_in = 6'd30; q_in = 64'd0;
            st_in = S_DIV;
         end
         S_DIV: begin
            if (dsh_ff <= 93'(acc_ff)) begin
               acc_in = acc_ff - 70'(dsh_ff);
               q_in = q_ff | (64'd1 << b_ff);
            end
            dsh_in = dsh_ff >> 1;
            b_in = b_ff - 6'd1;
            if (b_ff == 6'd0) st_in = S_EMA;
         end
         S_EMA: begin
            r_in = q_ff;
            st_in = S_WAITC;
         end
         S_WAITC: begin
            if (!have_prev_ff) sm_in = 32'sd0;
            else if (upd_ff) begin
               if (snew > 34'sd2147483647) sm_in = 32'sh7fffffff;
               else if (snew < -34'sd2147483648) sm_in = 32'sh80000000;
               else sm_in = 32'(snew);
            end
            have_prev_in = 1'b1;
            px_in = it_ff.pos_x; py_in = it_ff.pos_y; pz_in = it_ff.pos_z;
            pst_in = it_ff.stamp_ns;
            st_in = S_OUT;
         end
         S_OUT: begin
            if ((it_ff.action == phse_pkg::ACT_FAIL || ang_ok_ff) && (!ov_ff || rsp.ready))
            begin
               if (it_ff.action == phse_pkg::ACT_FAIL) begin
                  out_in = '0;
               end else begin
                  out_in.valid_res = 1'b1;
                  out_in.out_x = it_ff.pos_x;
                  out_in.out_y = it_ff.pos_y;
                  out_in.out_z = flat_ff ? 32'sd0 : it_ff.pos_z;
                  out_in.heading = head_ff;
                  out_in.speed = fb_ff ? fbs_ff : sm_ff;
               end
               ov_in = 1'b1;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; alpha_ff <= 17'd13107; flat_ff <= 1'b0;
         have_prev_ff <= 1'b0; px_ff <= '0; py_ff <= '0; pz_ff <= '0; pst_ff <= '0;
         sm_ff <= '0; fb_ff <= 1'b0; fbs_ff <= '0; ov_ff <= 1'b0; ang_ok_ff <= 1'b0;
      end else begin
         st_ff <= st_in; have_prev_ff <= have_prev_in;
         px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in; pst_ff <= pst_in;
         sm_ff <= sm_in; fb_ff <= fb_in; fbs_ff <= fbs_in; ov_ff <= ov_in;
         ang_ok_ff <= ang_ok_in;
         if (csr_wr) begin
            if (csr_paddr[2] == phse_pkg::REG_FLATTEN) flat_ff <= csr_pwdata[0];
            else alpha_ff <= csr_pwdata[16:0];
         end
      end
      it_ff <= it_in; upd_ff <= upd_in; dt_ff <= dt_in; k_ff <= k_in; b_ff <= b_in;
      acc_ff <= acc_in; r_ff <= r_in; rsq_ff <= rsq_in; dsh_ff <= dsh_in; q_ff <= q_in;
      head_ff <= head_in; out_ff <= out_in;
   end

   `CHECK_IMPL(a_busy_no_ready, clock, reset, st_ff != S_IDLE, !req.ready)
   `CHECK_NEXT(a_fail_result, clock, reset,
      st_ff == S_OUT && it_ff.action == phse_pkg::ACT_FAIL && (!ov_ff || rsp.ready),
      rsp.valid && !rsp.data.valid_res)
   `CHECK_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data))
endmodule

[dv/pose_heading_speed_estimator_tb.sv]
// Testbench for pose_heading_speed_estimator: random and directed items of every action
// checked against an in-bench predictor of position, CORDIC yaw and EMA speed.
// Depends on design/phse_pkg.sv, design/phse_if.sv and the estimator RTL.
`timescale 1ns / 1ps
module pose_heading_speed_estimator_tb;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [2:2] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   phse_if #(.payload_type(phse_pkg::req_type)) req_ch ();
   phse_if #(.payload_type(phse_pkg::rsp_type)) rsp_ch ();

   pose_heading_speed_estimator DUT (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // shadow of the block's registers and state
   logic [16:0] gain_q16;
   logic flat_shadow;
   logic seen_pose;
   logic signed [31:0] last_x, last_y, last_z;
   logic [62:0] last_stamp;
   logic signed [31:0] ema_speed;
   logic fb_held;
   logic signed [31:0] fb_speed;

   phse_pkg::req_type pending_items[$];
   phse_pkg::rsp_type expected_poses[$];
   int mismatches;
   int bad_fields;
   int burst_left, gap_left;
   int stall_tick;

   // generator state
   longint gen_x, gen_y, gen_z;
   logic [62:0] gen_stamp;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("status: fail");
      $finish;
   end

   function automatic longint angle_step(input int i);
      longint tab[24] = '{421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
         8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536, 32768,
         16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64};
      return tab[i];
   endfunction

   function automatic logic signed [15:0] yaw_of(input phse_pkg::req_type it);
      longint w, x, y, z, vx, vy, ang, t, nx, ny, h;
      w = it.quat_w; x = it.quat_x; y = it.quat_y; z = it.quat_z;
      vy = 2 * (w * z + x * y);
      vx = (64'sd1 <<< 30) - 2 * (y * y + z * z);
      ang = 0;
      if (vx == 0 && vy == 0) return '0;
      if (vx < 0) begin
         t = vx;
         if (vy >= 0) begin
            vx = vy; vy = -t; ang = phse_pkg::ANG_HALF_PI;
         end else begin
            vx = -vy; vy = t; ang = -phse_pkg::ANG_HALF_PI;
         end
      end
      for (int i = 0; i < 16; i++) begin
         if (vy > 0) begin
            nx = vx + (vy >>> i); ny = vy - (vx >>> i); ang += angle_step(i);
         end else begin
            nx = vx - (vy >>> i); ny = vy + (vx >>> i); ang -= angle_step(i);
         end
         vx = nx; vy = ny;
      end
      h = (ang + 32768) >>> 16;
      if (h > phse_pkg::HEAD_MAX) h = phse_pkg::HEAD_MAX;
      if (h < -phse_pkg::HEAD_MAX) h = -phse_pkg::HEAD_MAX;
      return h[15:0];
   endfunction

   function automatic longint step_speed(input phse_pkg::req_type it, input logic [62:0] dt);
      logic [127:0] ax, ay, az, sq, r, t, num, q;
      ax = (it.pos_x >= last_x) ? 128'(longint'(it.pos_x) - longint'(last_x))
                                : 128'(longint'(last_x) - longint'(it.pos_x));
      ay = (it.pos_y >= last_y) ? 128'(longint'(it.pos_y) - longint'(last_y))
                                : 128'(longint'(last_y) - longint'(it.pos_y));
      az = (it.pos_z >= last_z) ? 128'(longint'(it.pos_z) - longint'(last_z))
                                : 128'(longint'(last_z) - longint'(it.pos_z));
      sq = ax * ax + ay * ay + az * az;
      r = '0;
      for (int b = 34; b >= 0; b--) begin
         t = r | (128'd1 << b);
         if (t * t <= sq) r = t;
      end
      num = r * 128'd1000000000;
      q = '0;
      for (int b = 30; b >= 0; b--) begin
         t = q | (128'd1 << b);
         if (t * {65'd0, dt} <= num) q = t;
      end
      return longint'(q[63:0]);
   endfunction

   // returns 1 when the item yields a result
   function automatic bit estimate_pose(input phse_pkg::req_type it,
         output phse_pkg::rsp_type res);
      longint raw, a, s;
      res = '0;
      case (it.action)
         phse_pkg::ACT_FEEDBACK: begin
            fb_held = 1;
            fb_speed = it.feedback_speed_in;
            return 0;
         end
         phse_pkg::ACT_NONE: return 0;
         phse_pkg::ACT_FAIL: begin
            seen_pose = 0;
            return 1;
         end
         default: ;
      endcase
      if (seen_pose) begin
         if (it.stamp_ns > last_stamp && it.stamp_ns - last_stamp > 63'd1000) begin
            raw = step_speed(it, it.stamp_ns - last_stamp);
            a = (gain_q16 > 17'd65536) ? 65536 : longint'(gain_q16);
            s = longint'(ema_speed) + ((a * (raw - longint'(ema_speed)) + 32768) >>> 16);
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            ema_speed = s[31:0];
         end
      end else begin
         ema_speed = '0;
         seen_pose = 1;
      end
      last_x = it.pos_x; last_y = it.pos_y; last_z = it.pos_z;
      last_stamp = it.stamp_ns;
      res.valid_res = 1;
      res.out_x = it.pos_x;
      res.out_y = it.pos_y;
      res.out_z = flat_shadow ? '0 : it.pos_z;
      res.heading = yaw_of(it);
      res.speed = fb_held ? fb_speed : ema_speed;
      return 1;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_ch.valid <= 0;
         end else if (pending_items.size() > 0) begin
            req_ch.valid <= 1;
            req_ch.data <= pending_items.pop_front();
            if (burst_left == 0) begin
               burst_left <= $urandom_range(0, 12);
               gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_ch.valid <= 0;
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
         stall_tick <= 0;
      end else begin
         stall_tick <= stall_tick + 1;
         case (stall_tick[10:9])
            2'd0: rsp_ch.ready <= 1;
            2'd1: rsp_ch.ready <= $urandom_range(0, 1);
            2'd2: rsp_ch.ready <= (stall_tick[1:0] == 2'd0);
            default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      phse_pkg::rsp_type want, got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            if (estimate_pose(req_ch.data, want)) expected_poses.push_back(want);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (expected_poses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
               want = expected_poses.pop_front();
               bad_fields = 0;
               if (got.valid_res !== want.valid_res) bad_fields++;
               if (got.out_x !== want.out_x) bad_fields++;
               if (got.out_y !== want.out_y) bad_fields++;
               if (got.out_z !== want.out_z) bad_fields++;
               if (got.heading !== want.heading) bad_fields++;
               if (got.speed !== want.speed) bad_fields++;
               if (bad_fields != 0) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
      end
   end

   task automatic write_reg(input logic idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= idx;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      if (idx == phse_pkg::REG_ALPHA) gain_q16 = value[16:0];
      else flat_shadow = value[0];
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      while ((pending_items.size() > 0 || req_ch.valid || expected_poses.size() > 0)
             && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      if (waited >= 200000) begin
         $display("status: fail");
         $finish;
      end else begin
         repeat (300) @(posedge clock);
      end
   endtask

   function automatic phse_pkg::req_type pose_item(input longint x, input longint y,
         input longint z, input int w, input int qx, input int qy, input int qz,
         input logic [62:0] st);
      phse_pkg::req_type it;
      it = '0;
      it.action = phse_pkg::ACT_POSE;
      it.pos_x = x[31:0]; it.pos_y = y[31:0]; it.pos_z = z[31:0];
      it.quat_w = w[15:0]; it.quat_x = qx[15:0]; it.quat_y = qy[15:0]; it.quat_z = qz[15:0];
      it.stamp_ns = st;
      it.feedback_speed_in = $urandom;
      return it;
   endfunction

   task automatic add_random(input int n, input bit with_feedback);
      phse_pkg::req_type it;
      int pick;
      logic [62:0] dt;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         it = '0;
         it.action = phse_pkg::ACT_POSE;
         it.pos_x = $urandom; it.pos_y = $urandom; it.pos_z = $urandom;
         it.quat_w = 16'($urandom); it.quat_x = 16'($urandom);
         it.quat_y = 16'($urandom); it.quat_z = 16'($urandom);
         it.stamp_ns = 63'({$urandom, $urandom});
         it.feedback_speed_in = $urandom;
         if (pick < 4) begin
            it.action = phse_pkg::ACT_FAIL;
         end else if (pick < 8 && with_feedback) begin
            it.action = phse_pkg::ACT_FEEDBACK;
         end else if (pick < 10) begin
            it.action = phse_pkg::ACT_NONE;
         end else if (pick < 85) begin
            case ($urandom_range(0, 9))
               0: dt = 63'($urandom_range(0, 1000));
               1: dt = 63'd1001;
               2: dt = 63'({$urandom, $urandom});
               default: dt = 63'($urandom_range(1001, 200000000));
            endcase
            gen_stamp = $urandom_range(0, 30) == 0 ? gen_stamp - dt : gen_stamp + dt;
            if ($urandom_range(0, 9) == 0) begin
               gen_x = $signed(32'($urandom)); gen_y = $signed(32'($urandom));
               gen_z = $signed(32'($urandom));
            end else begin
               gen_x += $signed(32'($urandom_range(0, 400000))) - 200000;
               gen_y += $signed(32'($urandom_range(0, 400000))) - 200000;
               gen_z += $signed(32'($urandom_range(0, 40000))) - 20000;
            end
            it.pos_x = gen_x[31:0]; it.pos_y = gen_y[31:0]; it.pos_z = gen_z[31:0];
            it.stamp_ns = gen_stamp;
         end
         pending_items.push_back(it);
      end
   endtask

   initial begin
      phse_pkg::req_type it;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      req_ch.valid = 0; req_ch.data = '0; rsp_ch.ready = 0;
      gain_q16 = 17'd13107; flat_shadow = 0; seen_pose = 0;
      last_x = 0; last_y = 0; last_z = 0; last_stamp = 0; ema_speed = 0;
      fb_held = 0; fb_speed = 0; mismatches = 0;
      gen_x = 0; gen_y = 0; gen_z = 0; gen_stamp = 63'd5000;
      reset = 1;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset gain first, then extremes and corner stamps
      pending_items.push_back(pose_item(0, 0, 0, 32767, 0, 0, 0, 63'd0));
      pending_items.push_back(pose_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
         -32768, -32768, -32768, -32768, 63'd1001));
      pending_items.push_back(pose_item(-64'sd2147483648, -64'sd2147483648,
         -64'sd2147483648, 32767, 32767, 32767, 32767, 63'd2002));
      pending_items.push_back(pose_item(100, 200, 300, 0, 0, 16384, 16384, 63'd3002));
      pending_items.push_back(pose_item(65536, 0, 0, 0, 0, 32767, 0, 63'd3002));
      pending_items.push_back(pose_item(0, 65536, 0, 0, 0, 0, 32767, 63'd2000));
      pending_items.push_back(pose_item(1 << 20, 0, 0, 100, 0, 32000, -5000, 63'd9000));
      pending_items.push_back(pose_item(0, 0, 0, 100, 0, 32000, 5000,
         63'h7fffffffffffffff));
      it = pose_item(5, 5, 5, 1, 1, 1, 1, 63'd10);
      it.action = phse_pkg::ACT_FAIL;
      pending_items.push_back(it);
      it.action = phse_pkg::ACT_NONE;
      pending_items.push_back(it);
      pending_items.push_back(pose_item(7, 8, 9, -32768, 0, 0, 0, 63'd20000));
      pending_items.push_back(pose_item(70000, 80000, -90000, 1000, 2000, 3000, 4000,
         63'd1020000));
      drain();

      write_reg(phse_pkg::REG_ALPHA, 32'd65536);
      write_reg(phse_pkg::REG_FLATTEN, 32'd1);
      add_random(380, 0);
      drain();

      write_reg(phse_pkg::REG_ALPHA, 32'd0);
      write_reg(phse_pkg::REG_FLATTEN, 32'd0);
      add_random(380, 0);
      drain();

      write_reg(phse_pkg::REG_ALPHA, 32'h0001ffff);
      it = pose_item(0, 0, 0, 0, 0, 0, 0, 63'd0);
      it.action = phse_pkg::ACT_FEEDBACK;
      it.feedback_speed_in = 32'h80000000;
      pending_items.push_back(it);
      pending_items.push_back(pose_item(1, 2, 3, 30000, 0, 0, 100, gen_stamp));
      it.feedback_speed_in = 32'h7fffffff;
      pending_items.push_back(it);
      add_random(380, 1);
      drain();

      write_reg(phse_pkg::REG_ALPHA, $urandom_range(1, 65535));
      write_reg(phse_pkg::REG_FLATTEN, 32'd1);
      add_random(380, 1);
      drain();

      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

[filelist.f]
+incdir+design
design/phse_pkg.sv
design/phse_if.sv
design/phse_cordic.sv
design/pose_heading_speed_estimator.sv
dv/pose_heading_speed_estimator_tb.sv
